@@ sv/arce_pkg.sv @@
// Package for the audio-reactive color engine: codes, constants and shared types.
`default_nettype none
package arce_pkg;

	localparam logic [2:0] MODE_GRADIENT = 3'd0;
	localparam logic [2:0] MODE_PULSE    = 3'd1;
	localparam logic [2:0] MODE_SPECTRUM = 3'd2;
	localparam logic [2:0] MODE_ENERGY   = 3'd3;
	localparam logic [2:0] MODE_RAINBOW  = 3'd4;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_BRIGHT = 2'd1;
	localparam logic [1:0] REG_DECAY  = 2'd2;

	localparam logic [16:0] HUE_FULL  = 17'd92160;
	localparam logic [16:0] SECTOR    = 17'd15360;
	localparam logic [16:0] PULSE_MAX = 17'd131071;
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [16:0] SAT_LOW   = 17'd52428;
	localparam logic [16:0] HALF_Q16  = 17'd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STATE,
		ST_HUE,
		ST_HSV_C,
		ST_HSV_P,
		ST_HSV_X,
		ST_COLOR,
		ST_OUT
	} arce_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic do_state;
		logic do_hue;
		logic do_c;
		logic do_p;
		logic do_x;
		logic do_color;
	} arce_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic uses_hsv;
	} arce_status_t;

	function automatic logic [7:0] clamp255(input logic [47:0] v);
		return (v > 48'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/audio_reactive_color_engine.sv @@
// Top level of the audio-reactive color engine.
`default_nettype none
// One RGB pixel per audio analysis frame. A request is taken in the idle cycle,
// followed by the effect state update, then hue and value, then the step that
// forms the color; the pixel is offered from the next cycle on. The
// energy-wave and rainbow effects add HSV steps before the color (chroma, chroma
// times the sector offset, divide by the sector width). While the receiver holds
// off, the pixel waits and the frame lasts longer. The next request is
// taken only after the pixel has been taken. The user must write the registers
// only when idle; the block itself does not enforce it.
module audio_reactive_color_engine
	import arce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: rms_level[12:0], bass_level[25:13], mid_level[38:26], treble_level[51:39]
	input  wire logic [55:0] s_tdata,
	// tuser: beat_flag
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic [23:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	logic [2:0]  mode_q;
	logic [8:0]  bright_q;
	logic [16:0] decay_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_GRADIENT;
			bright_q <= 9'd256;
			decay_q  <= 17'd62259;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[2:0];
				REG_BRIGHT: bright_q <= cfg_data[8:0];
				REG_DECAY:  decay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	arce_cmd_t    cmd;
	arce_status_t status;
	logic         busy;

	assign s_tready = !busy;

	arce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_req(s_tvalid), .out_taken(m_tready),
		.status(status), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	arce_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.effect_mode(mode_q), .brightness(bright_q), .decay_rate(decay_q),
		.rms_level(s_tdata[12:0]), .beat_flag(s_tuser),
		.bass_level(s_tdata[25:13]), .mid_level(s_tdata[38:26]),
		.treble_level(s_tdata[51:39]), .status(status),
		.red_out(m_tdata[7:0]), .green_out(m_tdata[15:8]), .blue_out(m_tdata[23:16])
	);

	logic unused_pad;
	assign unused_pad = ^s_tdata[55:52];

	// A request is only taken while no pixel waits.
	a_no_take_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken while pixel pending");

	// A taken request yields its pixel only after the state update, hue and color steps.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid [*3]) else $error("pixel too early");

endmodule
`default_nettype wire

@@ sv/arce_ctrl.sv @@
// Controller state machine that sequences one frame through the datapath.
`default_nettype none
module arce_ctrl
	import arce_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_req,
	input  wire logic         out_taken,
	input  wire arce_status_t status,
	output arce_cmd_t         cmd,
	output logic              busy,
	output logic              out_valid
);

	arce_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (in_req) state_next = ST_STATE;
			ST_STATE: state_next = ST_HUE;
			ST_HUE:   state_next = status.uses_hsv ? ST_HSV_C : ST_COLOR;
			ST_HSV_C: state_next = ST_HSV_P;
			ST_HSV_P: state_next = ST_HSV_X;
			ST_HSV_X: state_next = ST_COLOR;
			ST_COLOR: state_next = ST_OUT;
			ST_OUT:   if (out_taken) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_req;
			end
			ST_STATE: cmd.do_state = 1'b1;
			ST_HUE:   cmd.do_hue = 1'b1;
			ST_HSV_C: cmd.do_c = 1'b1;
			ST_HSV_P: cmd.do_p = 1'b1;
			ST_HSV_X: cmd.do_x = 1'b1;
			ST_COLOR: cmd.do_color = 1'b1;
			ST_OUT:   out_valid = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/arce_dp.sv @@
// Datapath: effect state registers, HSV conversion and color scaling.
`default_nettype none
module arce_dp
	import arce_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire arce_cmd_t    cmd,
	input  wire logic [2:0]   effect_mode,
	input  wire logic [8:0]   brightness,
	input  wire logic [16:0]  decay_rate,
	input  wire logic [12:0]  rms_level,
	input  wire logic         beat_flag,
	input  wire logic [12:0]  bass_level,
	input  wire logic [12:0]  mid_level,
	input  wire logic [12:0]  treble_level,
	output arce_status_t      status,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out
);

	logic [12:0] r_q, bass_q, mid_q, treb_q;
	logic        beat_q;
	logic [2:0]  mode_q;
	logic [16:0] pulse_q, energy_q, hue_q;
	logic [16:0] s_q;
	logic [17:0] v_q, c_q, x_q;
	logic [2:0]  sector_q;
	logic [13:0] f_q;

	// Latch the frame request and the mode it is rendered with.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q    <= rms_level;
			beat_q <= beat_flag;
			bass_q <= bass_level;
			mid_q  <= mid_level;
			treb_q <= treble_level;
			mode_q <= effect_mode;
		end
	end

	assign status.uses_hsv = (mode_q == MODE_ENERGY) || (mode_q == MODE_RAINBOW);

	// State update: the pulse or energy decay multiply, or the rainbow hue advance, once per frame.
	logic [17:0] pulse_pre, energy_pre;
	logic [34:0] pulse_prod, energy_prod;
	logic [17:0] hue_sum;
	assign pulse_pre   = beat_q ? {1'b0, ONE_Q16} : {1'b0, pulse_q};
	assign energy_pre  = {1'b0, energy_q} + (beat_q ? {1'b0, HALF_Q16} : 18'd0);
	assign pulse_prod  = 35'(({17'd0, pulse_pre} * {18'd0, decay_rate}) >> 16);
	assign energy_prod = 35'(({17'd0, energy_pre} * {18'd0, decay_rate}) >> 16);
	assign hue_sum     = {1'b0, hue_q} + 18'(r_q[12:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= '0;
			energy_q <= '0;
			hue_q    <= '0;
		end else if (cmd.do_state) begin
			case (mode_q)
				MODE_PULSE:
					pulse_q <= (pulse_prod > 35'(PULSE_MAX)) ? PULSE_MAX : pulse_prod[16:0];
				MODE_ENERGY:
					energy_q <= (energy_prod > 35'(ONE_Q16)) ? ONE_Q16 : energy_prod[16:0];
				MODE_RAINBOW:
					hue_q <= (hue_sum >= {1'b0, HUE_FULL}) ? 17'(hue_sum - {1'b0, HUE_FULL})
						: hue_sum[16:0];
				default: ;
			endcase
		end
	end

	// Hue, saturation and value for the HSV effects.
	logic [25:0] ehue;
	logic [16:0] ehue_w, hsel;
	logic [16:0] vr;
	logic [17:0] r_sh;
	logic [17:0] v_energy, v_rain;
	assign ehue     = 26'({9'd0, energy_q} * 26'd360) >> 8;
	assign ehue_w   = (ehue >= 26'(HUE_FULL)) ? 17'(ehue - 26'(HUE_FULL)) : ehue[16:0];
	assign hsel     = (mode_q == MODE_ENERGY) ? ehue_w : hue_q;
	assign r_sh     = {r_q, 5'd0};
	assign vr       = beat_q ? ONE_Q16
		: ((r_sh > 18'(ONE_Q16)) ? ONE_Q16 : r_sh[16:0]);
	assign v_energy = 18'(({13'd0, r_q} * {17'd0, brightness}) >> 4);
	assign v_rain   = 18'(({9'd0, vr} * {17'd0, brightness}) >> 8);

	// Sector by compare against sector multiples.
	logic [2:0]  sec;
	logic [16:0] base;
	always_comb begin
		if (hsel >= 17'd76800) begin sec = 3'd5; base = 17'd76800; end
		else if (hsel >= 17'd61440) begin sec = 3'd4; base = 17'd61440; end
		else if (hsel >= 17'd46080) begin sec = 3'd3; base = 17'd46080; end
		else if (hsel >= 17'd30720) begin sec = 3'd2; base = 17'd30720; end
		else if (hsel >= SECTOR) begin sec = 3'd1; base = SECTOR; end
		else begin sec = 3'd0; base = 17'd0; end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_hue) begin
			sector_q <= sec;
			f_q      <= 14'(hsel - base);
			if (mode_q == MODE_ENERGY) begin
				s_q <= ONE_Q16;
				v_q <= v_energy;
			end else begin
				s_q <= beat_q ? ONE_Q16 : SAT_LOW;
				v_q <= v_rain;
			end
		end
	end

	// Chroma, then chroma times the sector offset, then the secondary part.
	// The divide by 15360 is a shift by 10 followed by a reciprocal multiply for 15.
	logic [34:0] c_prod;
	logic [13:0] fsel;
	logic [21:0] cf, cf_q;
	assign c_prod = {17'd0, v_q} * {18'd0, s_q};
	assign fsel   = sector_q[0] ? 14'(SECTOR - 17'(f_q)) : f_q;
	assign cf     = 22'(({14'd0, c_q} * {18'd0, fsel}) >> 10);

	// 2^26 / 15 rounded up gives the exact quotient for every value below 2^22.
	always_ff @(posedge clk) begin
		if (cmd.do_c) c_q <= 18'(c_prod >> 16);
		if (cmd.do_p) cf_q <= cf;
		if (cmd.do_x) x_q <= 18'((45'(cf_q) * 45'd4473925) >> 26);
	end

	// Final color per effect.
	logic [17:0] m, pr, pg, pb;
	logic [47:0] br;
	assign m  = v_q - c_q;
	assign br = {39'd0, brightness};
	always_comb begin
		case (sector_q)
			3'd0: begin pr = c_q; pg = x_q; pb = '0; end
			3'd1: begin pr = x_q; pg = c_q; pb = '0; end
			3'd2: begin pr = '0; pg = c_q; pb = x_q; end
			3'd3: begin pr = '0; pg = x_q; pb = c_q; end
			3'd4: begin pr = x_q; pg = '0; pb = c_q; end
			default: begin pr = c_q; pg = '0; pb = x_q; end
		endcase
	end

	function automatic logic [7:0] hsv_comp(input logic [17:0] p, input logic [17:0] mm);
		logic [47:0] t;
		t = ({29'd0, 19'({1'b0, p} + {1'b0, mm})} * 48'd255) >> 16;
		return clamp255(t);
	endfunction

	logic [47:0] r48, b48, m48, t48, p48;
	logic [7:0] rn, gn, bn;
	always_comb begin
		r48 = {35'd0, r_q};
		p48 = {31'd0, pulse_q};
		t48 = {35'd0, treb_q};
		b48 = {35'd0, bass_q};
		m48 = {35'd0, mid_q};
		rn = '0; gn = '0; bn = '0;
		case (mode_q)
			MODE_GRADIENT: begin
				rn = clamp255((r48 * 48'd255 * br) >> 20);
				gn = beat_q ? clamp255((48'd255 * br) >> 8)
					: clamp255((r48 * 48'd128 * br) >> 20);
				bn = (r_q >= 13'd4096) ? 8'd0
					: clamp255(((48'd4096 - r48) * 48'd255 * br) >> 20);
			end
			MODE_PULSE: begin
				rn = clamp255((48'd255 * br * p48) >> 24);
				gn = clamp255((48'd100 * br * p48) >> 24);
				bn = clamp255((48'd50 * br * p48) >> 24);
			end
			MODE_SPECTRUM: begin
				rn = clamp255((b48 * 48'd255 * br) >> 20);
				gn = clamp255((m48 * 48'd255 * br) >> 20);
				bn = clamp255((t48 * 48'd255 * br) >> 20);
			end
			MODE_ENERGY, MODE_RAINBOW: begin
				rn = hsv_comp(pr, m);
				gn = hsv_comp(pg, m);
				bn = hsv_comp(pb, m);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.do_color) begin
			red_out   <= rn;
			green_out <= gn;
			blue_out  <= bn;
		end
	end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the audio-reactive color engine.
`default_nettype none
module testbench;
	import arce_pkg::*;

	// Codes outside the defined sets, used to check that they are ignored.
	localparam logic [1:0] REG_UNUSED     = 2'd3;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [12:0] rms;
		logic        beat;
		logic [12:0] bass;
		logic [12:0] mid;
		logic [12:0] treble;
	} frame_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// One row of the directed table; has_pix marks rows with a typed-in pixel.
	typedef struct {
		frame_t frm;
		logic   has_pix;
		pixel_t pix;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;

	audio_reactive_color_engine dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of registers and effect state.
	logic [2:0]  mdl_mode;
	logic [8:0]  mdl_bright;
	logic [16:0] mdl_decay;
	logic [16:0] mdl_pulse;
	logic [16:0] mdl_energy;
	logic [16:0] mdl_hue;

	pixel_t pix_q[$];
	int     fails = 0;
	bit     no_idle = 0;
	bit     hold_off = 0;
	bit     done = 0;
	int     idle_cycles = 0;
	int     stall_left = 0;

	function automatic logic [7:0] sat8(input logic [63:0] v);
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic pixel_t hsv_pixel(input logic [63:0] hue, input logic [63:0] s,
			input logic [63:0] v);
		logic [63:0] sec, f, c, x, m;
		logic [63:0] p [3];
		pixel_t px;
		sec = (hue / 15360) % 6;
		f = hue % 15360;
		c = (v * s) >> 16;
		x = sec[0] ? (c * (15360 - f)) / 15360 : (c * f) / 15360;
		m = v - c;
		case (sec)
			0: begin p[0] = c; p[1] = x; p[2] = '0; end
			1: begin p[0] = x; p[1] = c; p[2] = '0; end
			2: begin p[0] = '0; p[1] = c; p[2] = x; end
			3: begin p[0] = '0; p[1] = x; p[2] = c; end
			4: begin p[0] = x; p[1] = '0; p[2] = c; end
			default: begin p[0] = c; p[1] = '0; p[2] = x; end
		endcase
		px.red = sat8(((p[0] + m) * 255) >> 16);
		px.green = sat8(((p[1] + m) * 255) >> 16);
		px.blue = sat8(((p[2] + m) * 255) >> 16);
		return px;
	endfunction

	// Computes the pixel for one frame and advances the effect state.
	function automatic pixel_t render_frame(input frame_t fr);
		logic [63:0] r, b, t, s, v;
		pixel_t px;
		r = 64'(fr.rms);
		b = 64'(mdl_bright);
		px = '0;
		case (mdl_mode)
			MODE_GRADIENT: begin
				px.red = sat8((r * 255 * b) >> 20);
				px.green = fr.beat ? sat8((255 * b) >> 8) : sat8((r * 128 * b) >> 20);
				px.blue = (r >= 4096) ? 8'd0 : sat8(((4096 - r) * 255 * b) >> 20);
			end
			MODE_PULSE: begin
				if (fr.beat)
					mdl_pulse = ONE_Q16;
				t = (64'(mdl_pulse) * mdl_decay) >> 16;
				mdl_pulse = (t > PULSE_MAX) ? PULSE_MAX : t[16:0];
				px.red = sat8((255 * b * mdl_pulse) >> 24);
				px.green = sat8((100 * b * mdl_pulse) >> 24);
				px.blue = sat8((50 * b * mdl_pulse) >> 24);
			end
			MODE_SPECTRUM: begin
				px.red = sat8((64'(fr.bass) * 255 * b) >> 20);
				px.green = sat8((64'(fr.mid) * 255 * b) >> 20);
				px.blue = sat8((64'(fr.treble) * 255 * b) >> 20);
			end
			MODE_ENERGY: begin
				t = 64'(mdl_energy) + (fr.beat ? 64'd32768 : 64'd0);
				t = (t * mdl_decay) >> 16;
				mdl_energy = (t > ONE_Q16) ? ONE_Q16 : t[16:0];
				t = (64'(mdl_energy) * 360) >> 8;
				if (t >= HUE_FULL)
					t = t - 64'(HUE_FULL);
				px = hsv_pixel(t, 64'(ONE_Q16), (r * b) >> 4);
			end
			MODE_RAINBOW: begin
				mdl_hue = 17'((64'(mdl_hue) + (r >> 3)) % HUE_FULL);
				if (fr.beat) begin
					s = 64'(ONE_Q16);
					v = 64'(ONE_Q16);
				end else begin
					s = 64'(SAT_LOW);
					v = r << 5;
					if (v > ONE_Q16)
						v = 64'(ONE_Q16);
				end
				px = hsv_pixel(64'(mdl_hue), s, (v * b) >> 8);
			end
			default: px = '0;
		endcase
		return px;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: mdl_mode = val[2:0];
			REG_BRIGHT: mdl_bright = val[8:0];
			REG_DECAY: mdl_decay = val;
			default: ;
		endcase
	endtask

	// Stops offering, waits for all expected pixels, then lets the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pix_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Offers one frame, with an optional random gap, and waits for its acceptance.
	// The request stays offered after acceptance until the next frame, a gap or a drain.
	task automatic send_frame(input frame_t fr, input bit has_pix, input pixel_t pix);
		pixel_t exp_pix;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		exp_pix = render_frame(fr);
		if (has_pix && exp_pix != pix) begin
			$error("table row disagrees with predictor: %h vs %h", pix, exp_pix);
			fails++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, fr.treble, fr.mid, fr.bass, fr.rms};
		s_tuser <= fr.beat;
		pix_q.push_back(has_pix ? pix : exp_pix);
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [12:0] rand_level();
		case ($urandom_range(0, 7))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'($urandom_range(4097, 8191));
			default: return 13'($urandom_range(0, 4096));
		endcase
	endfunction

	// Receiver: random stall bursts, always ready under no_idle, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else if (no_idle)
			m_tready <= 1'b1;
		else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left <= int'($urandom_range(0, 15));
		end else
			m_tready <= 1'b1;
	end

	// Pixel checker.
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pix_q.size() == 0) begin
				$error("unexpected pixel %h", got);
				fails++;
			end else begin
				want = pix_q.pop_front();
				if (got.red !== want.red) begin
					$error("red_out expected %0d actual %0d", want.red, got.red);
					fails++;
				end
				if (got.green !== want.green) begin
					$error("green_out expected %0d actual %0d", want.green, got.green);
					fails++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_out expected %0d actual %0d", want.blue, got.blue);
					fails++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or pixel, outside the hold-off.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !done) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		frame_t fr;
		logic [2:0] modes [8];
		logic [8:0] brights [4];
		logic [16:0] decays [4];

		modes = '{MODE_GRADIENT, MODE_PULSE, MODE_SPECTRUM, MODE_ENERGY,
			MODE_RAINBOW, MODE_UNUSED_LO, MODE_UNUSED_HI, MODE_RAINBOW};
		brights = '{9'd256, 9'd0, 9'd511, 9'd128};
		decays = '{17'd62259, 17'd0, 17'd131071, 17'd65536};
		mdl_mode = MODE_GRADIENT;
		mdl_bright = 9'd256;
		mdl_decay = 17'd62259;
		mdl_pulse = '0;
		mdl_energy = '0;
		mdl_hue = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed gradient rows at reset settings: pixels read off directly, the last from the predictor.
		rows.push_back('{'{13'd0, 1'b0, 13'd0, 13'd0, 13'd0}, 1'b1, '{8'd255, 8'd0, 8'd0}});
		rows.push_back('{'{13'd4096, 1'b0, 13'd0, 13'd0, 13'd0}, 1'b1,
			'{8'd0, 8'd128, 8'd255}});
		rows.push_back('{'{13'd4096, 1'b1, 13'd0, 13'd0, 13'd0}, 1'b1,
			'{8'd0, 8'd255, 8'd255}});
		rows.push_back('{'{13'd8191, 1'b0, 13'd8191, 13'd8191, 13'd8191}, 1'b1,
			'{8'd0, 8'd255, 8'd255}});
		rows.push_back('{'{13'd2048, 1'b1, 13'd1, 13'd4096, 13'd2}, 1'b0, '0});
		foreach (rows[i])
			send_frame(rows[i].frm, rows[i].has_pix, rows[i].pix);
		drain();

		// Directed: each mode and the unused codes with extremes, beats and silence.
		for (int md = 0; md < 8; md++) begin
			write_reg(REG_MODE, 17'(modes[md]));
			send_frame('{13'd4096, 1'b1, 13'd4096, 13'd0, 13'd8191}, 0, '0);
			send_frame('{13'd8191, 1'b0, 13'd0, 13'd8191, 13'd4096}, 0, '0);
			send_frame('{13'd0, 1'b0, 13'd1, 13'd1, 13'd1}, 0, '0);
			drain();
		end

		// Random phases over register settings, with one long receiver hold-off.
		for (int ph = 0; ph < 30; ph++) begin
			write_reg(REG_MODE, 17'(ph < 24 ? modes[ph % 8] : $urandom_range(0, 7)));
			write_reg(REG_BRIGHT, 17'(ph < 8 ? brights[ph % 4] : $urandom_range(0, 511)));
			write_reg(REG_DECAY, ph < 12 ? decays[ph % 4] :
				17'($urandom_range(0, 131071)));
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, 17'($urandom));
			if (ph == 25)
				no_idle = 1;
			if (ph == 3)
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			for (int k = 0; k < 50; k++) begin
				fr.rms = rand_level();
				fr.beat = ($urandom_range(0, 4) == 0);
				fr.bass = rand_level();
				fr.mid = rand_level();
				fr.treble = rand_level();
				send_frame(fr, 0, '0);
			end
			drain();
		end

		done = 1;
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
